[rtl/itoa_pkg.sv]
// shared types, codes and character helpers for the integer to ascii formatter
`default_nettype none

package itoa_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 64;
    localparam int VALUE_FIELD_W       = 64;

    // conversion kinds
    localparam logic [2:0] KIND_SDEC   = 3'd0;
    localparam logic [2:0] KIND_UDEC   = 3'd1;
    localparam logic [2:0] KIND_OCT    = 3'd2;
    localparam logic [2:0] KIND_HEX_LO = 3'd3;
    localparam logic [2:0] KIND_HEX_UP = 3'd4;

    localparam logic [7:0] CHAR_MINUS  = 8'h2d;
    localparam logic [7:0] CHAR_PLUS   = 8'h2b;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_A_UP   = 8'h41;
    localparam logic [7:0] CHAR_A_LO   = 8'h61;

    typedef struct packed {
        logic signed [VALUE_FIELD_W-1:0] value;
        logic [2:0]                      kind;
        logic                            plus_flag;
        logic                            space_flag;
    } item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       is_last;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic dabble;
        logic split;
        logic emit_prefix;
        logic emit_digit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic item_is_dec;
        logic dabble_last;
        logic split_last;
        logic has_prefix;
        logic digit_last;
    } stat_t;

    // unused kind codes fall back to unsigned decimal
    function automatic logic kind_is_dec(input logic [2:0] kind);
        return !(kind inside {KIND_OCT, KIND_HEX_LO, KIND_HEX_UP});
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base_char;
        base_char = upper ? CHAR_A_UP : CHAR_A_LO;
        if (d < 4'd10)
            return CHAR_ZERO + {4'd0, d};
        else
            return base_char + {4'd0, d - 4'd10};
    endfunction

endpackage

`default_nettype wire

[rtl/itoa_dp.sv]
// datapath: magnitude, bit-serial binary to bcd, digit store and character output
`default_nettype none

module itoa_dp #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire itoa_pkg::item_t item,
    input  wire itoa_pkg::cmd_t  cmd,
    output itoa_pkg::stat_t      stat,
    output itoa_pkg::result_t    result,
    output logic                 strobe
);

    // decimal digits of the largest unsigned value
    localparam int DEC_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int WORK_W     = 4 * DEC_DIGITS;
    localparam int DEPTH      = (VALUE_WIDTH + 2) / 3;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int BCNT_W     = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] bin_reg;
    logic [WORK_W-1:0]      work_reg;
    logic [BCNT_W-1:0]      bit_cnt_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic                   is_oct_reg;
    logic                   upper_reg;
    logic                   has_prefix_reg;
    logic [7:0]             prefix_reg;
    logic [3:0]             digit_store [DEPTH];
    itoa_pkg::result_t      result_reg;
    logic                   strobe_reg;

    logic [VALUE_WIDTH-1:0] v;
    logic                   in_dec;
    logic                   negative;
    logic [VALUE_WIDTH-1:0] mag;
    logic [WORK_W-1:0]      adj;
    logic [WORK_W-1:0]      work_shift;
    logic [3:0]             split_digit;
    logic [3:0]             rd_digit;

    assign v        = item.value[VALUE_WIDTH-1:0];
    assign in_dec   = itoa_pkg::kind_is_dec(item.kind);
    assign negative = (item.kind == itoa_pkg::KIND_SDEC) && v[VALUE_WIDTH-1];
    assign mag      = negative ? (~v + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : v;

    // add three to every bcd digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (work_reg[4*i +: 4] >= 4'd5)
                adj[4*i +: 4] = work_reg[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = work_reg[4*i +: 4];
        end
    end

    assign split_digit = is_oct_reg ? {1'b0, work_reg[2:0]} : work_reg[3:0];
    assign work_shift  = is_oct_reg ? (work_reg >> 3) : (work_reg >> 4);
    assign rd_digit    = digit_store[rd_idx_reg];

    assign stat.item_is_dec = in_dec;
    assign stat.dabble_last = (bit_cnt_reg == BCNT_W'(VALUE_WIDTH - 1));
    assign stat.split_last  = (work_shift == '0) || (count_reg == CNT_W'(DEPTH - 1));
    assign stat.has_prefix  = has_prefix_reg;
    assign stat.digit_last  = (rd_idx_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            is_oct_reg     <= (item.kind == itoa_pkg::KIND_OCT);
            upper_reg      <= (item.kind == itoa_pkg::KIND_HEX_UP);
            has_prefix_reg <= negative || item.plus_flag || item.space_flag;
            prefix_reg     <= negative       ? itoa_pkg::CHAR_MINUS :
                              item.plus_flag ? itoa_pkg::CHAR_PLUS  : itoa_pkg::CHAR_SPACE;
            bin_reg        <= mag;
            work_reg       <= in_dec ? '0 : WORK_W'(mag);
            bit_cnt_reg    <= '0;
            count_reg      <= '0;
        end
        else if (cmd.dabble)
        begin
            work_reg    <= {adj[WORK_W-2:0], bin_reg[VALUE_WIDTH-1]};
            bin_reg     <= bin_reg << 1;
            bit_cnt_reg <= bit_cnt_reg + BCNT_W'(1);
        end
        else if (cmd.split)
        begin
            digit_store[count_reg[IDX_W-1:0]] <= split_digit;
            work_reg   <= work_shift;
            count_reg  <= count_reg + CNT_W'(1);
            rd_idx_reg <= count_reg[IDX_W-1:0];
        end
        else if (cmd.emit_digit)
        begin
            rd_idx_reg <= rd_idx_reg - IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_prefix)
        begin
            result_reg.out_char <= prefix_reg;
            result_reg.is_last  <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            result_reg.out_char <= itoa_pkg::digit_char(rd_digit, upper_reg);
            result_reg.is_last  <= (rd_idx_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= cmd.emit_prefix || cmd.emit_digit;
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

endmodule

`default_nettype wire

[rtl/itoa_ctrl.sv]
// controller: sequences conversion, digit split and character output
`default_nettype none

module itoa_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire itoa_pkg::stat_t stat,
    output itoa_pkg::cmd_t       cmd,
    output logic                 busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DABBLE,
        S_SPLIT,
        S_PREFIX,
        S_DIGITS
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.item_is_dec ? S_DABBLE : S_SPLIT;
                end
            end
            S_DABBLE:
            begin
                cmd.dabble = 1'b1;
                if (stat.dabble_last)
                    state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                cmd.split = 1'b1;
                if (stat.split_last)
                    state_next = stat.has_prefix ? S_PREFIX : S_DIGITS;
            end
            S_PREFIX:
            begin
                cmd.emit_prefix = 1'b1;
                state_next      = S_DIGITS;
            end
            S_DIGITS:
            begin
                cmd.emit_digit = 1'b1;
                if (stat.digit_last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

[rtl/integer_to_ascii_formatter.sv]
// top level of the integer to ascii formatter
`default_nettype none

// Formats one integer per start pulse as printf-style d/u/o/x/X text and sends it
// out one character per strobe, most significant first, with is_last on the final
// character. A word is taken when start is high and busy is low; each result word
// is valid for exactly one cycle with strobe and cannot be held off, so the
// receiver must take every strobe. Decimal kinds first run a bit-serial binary to
// bcd conversion over all VALUE_WIDTH bits (64 by default); every kind then splits
// one digit per cycle into the digit store and reads one character per cycle back
// out. A sign or space prefix adds at most one character. The last strobe is in
// the first cycle with busy low, the same cycle in which the next word can be taken.
module integer_to_ascii_formatter #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire itoa_pkg::item_t item,
    output logic                 busy,
    output itoa_pkg::result_t    result,
    output logic                 strobe
);

    itoa_pkg::cmd_t  cmd;
    itoa_pkg::stat_t stat;

    itoa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    itoa_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result),
        .strobe (strobe)
    );

endmodule

`default_nettype wire

[tb/tb_integer_to_ascii_formatter.sv]
// self-checking testbench for the integer to ascii formatter
module tb_integer_to_ascii_formatter;

    localparam int MAX_DIGITS   = 22;
    localparam int RANDOM_ITEMS = 78;
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 200000;

    // predicts the text of each accepted number and checks the characters that come back
    class char_board;
        itoa_pkg::result_t pending_chars[$];
        int      errors;
        int      reported;
        int      chars_checked;
        int      numbers_seen;

        function new();
            errors = 0;
            reported = 0;
            chars_checked = 0;
            numbers_seen = 0;
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction

        function void note_fault(string what, itoa_pkg::result_t want,
                                 itoa_pkg::result_t got);
            errors++;
            if (reported < 10)
            begin
                reported++;
                $display("mismatch (%s): expected char %h last %b, got char %h last %b",
                         what, want.out_char, want.is_last, got.out_char, got.is_last);
            end
        endfunction

        function void note_number(itoa_pkg::item_t it);
            string       lower_digits;
            string       upper_digits;
            logic [63:0] raw;
            logic [63:0] mag;
            logic [63:0] radix;
            logic        neg;
            logic        upper;
            logic [3:0]  digs [MAX_DIGITS];
            int          n;
            itoa_pkg::result_t r;
            lower_digits = "0123456789abcdef";
            upper_digits = "0123456789ABCDEF";
            raw = it.value;
            neg = (it.kind == itoa_pkg::KIND_SDEC) && raw[63];
            upper = (it.kind == itoa_pkg::KIND_HEX_UP);
            if (it.kind == itoa_pkg::KIND_OCT)
                radix = 64'd8;
            else if (it.kind == itoa_pkg::KIND_HEX_LO || it.kind == itoa_pkg::KIND_HEX_UP)
                radix = 64'd16;
            else
                radix = 64'd10;
            // unsigned negate keeps the most negative value exact
            mag = neg ? (64'd0 - raw) : raw;
            n = 0;
            do
            begin
                digs[n] = 4'(mag % radix);
                n++;
                mag = mag / radix;
            end
            while (mag != 64'd0 && n < MAX_DIGITS);
            r.is_last = 1'b0;
            if (neg)
            begin
                r.out_char = itoa_pkg::CHAR_MINUS;
                pending_chars.push_back(r);
            end
            else if (it.plus_flag)
            begin
                r.out_char = itoa_pkg::CHAR_PLUS;
                pending_chars.push_back(r);
            end
            else if (it.space_flag)
            begin
                r.out_char = itoa_pkg::CHAR_SPACE;
                pending_chars.push_back(r);
            end
            for (int i = n - 1; i >= 0; i--)
            begin
                r.out_char = upper ? upper_digits[digs[i]] : lower_digits[digs[i]];
                r.is_last = (i == 0);
                pending_chars.push_back(r);
            end
            numbers_seen++;
        endfunction

        function void compare_char(itoa_pkg::result_t got);
            itoa_pkg::result_t want;
            if (pending_chars.size() == 0)
            begin
                want = '0;
                note_fault("unexpected word", want, got);
                return;
            end
            want = pending_chars.pop_front();
            chars_checked++;
            if (got.out_char !== want.out_char)
                note_fault("out_char", want, got);
            if (got.is_last !== want.is_last)
                note_fault("is_last", want, got);
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    itoa_pkg::item_t   item;
    logic              busy;
    itoa_pkg::result_t result;
    logic              strobe;

    char_board board;
    int        cycles;
    int        gap_pct;

    integer_to_ascii_formatter uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .result (result),
        .strobe (strobe)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            board.compare_char(result);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic itoa_pkg::item_t make_item(logic signed [63:0] v, logic [2:0] k,
                                                  logic p, logic s);
        itoa_pkg::item_t it;
        it.value = v;
        it.kind = k;
        it.plus_flag = p;
        it.space_flag = s;
        return it;
    endfunction

    function automatic itoa_pkg::item_t random_item();
        logic [63:0] v;
        int          k;
        int          mode;
        v = {$urandom(), $urandom()};
        mode = $urandom_range(0, 3);
        // mix short and long numbers so digit counts vary
        if (mode == 1)
            v = v >> $urandom_range(1, 63);
        else if (mode == 2)
            v = ~(v >> $urandom_range(1, 63));
        k = $urandom_range(0, 19);
        return make_item(v, (k < 16) ? 3'(k % 5) : ((k < 19) ? 3'(k - 11) : 3'd7),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    // holds start up until the word is taken; called right after the clock rises
    task automatic send_word(itoa_pkg::item_t it);
        start <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (busy);
        board.note_number(it);
    endtask

    task automatic pause_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain_text();
        start <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic directed_words();
        logic signed [63:0] most_neg;
        logic signed [63:0] most_pos;
        most_neg = {1'b1, 63'd0};
        most_pos = {1'b0, {63{1'b1}}};
        send_word(make_item(64'sd0, itoa_pkg::KIND_SDEC, 1'b0, 1'b0));
        send_word(make_item(64'sd0, itoa_pkg::KIND_UDEC, 1'b1, 1'b0));
        send_word(make_item(64'sd0, itoa_pkg::KIND_OCT, 1'b0, 1'b1));
        send_word(make_item(64'sd0, itoa_pkg::KIND_HEX_LO, 1'b1, 1'b1));
        send_word(make_item(64'sd0, itoa_pkg::KIND_HEX_UP, 1'b0, 1'b0));
        send_word(make_item(most_pos, itoa_pkg::KIND_SDEC, 1'b1, 1'b0));
        send_word(make_item(most_neg, itoa_pkg::KIND_SDEC, 1'b1, 1'b1));
        send_word(make_item(most_neg, itoa_pkg::KIND_UDEC, 1'b0, 1'b0));
        send_word(make_item(most_neg, itoa_pkg::KIND_OCT, 1'b0, 1'b1));
        send_word(make_item(most_neg, itoa_pkg::KIND_HEX_UP, 1'b0, 1'b0));
        send_word(make_item(-64'sd1, itoa_pkg::KIND_SDEC, 1'b0, 1'b1));
        send_word(make_item(-64'sd1, itoa_pkg::KIND_UDEC, 1'b1, 1'b0));
        // all ones in octal with a sign gives the longest text
        send_word(make_item(-64'sd1, itoa_pkg::KIND_OCT, 1'b1, 1'b0));
        send_word(make_item(-64'sd1, itoa_pkg::KIND_HEX_LO, 1'b0, 1'b1));
        send_word(make_item(-64'sd1, itoa_pkg::KIND_HEX_UP, 1'b1, 1'b1));
        send_word(make_item(64'sd1, itoa_pkg::KIND_SDEC, 1'b0, 1'b1));
        send_word(make_item(64'sh00ab_cdef_1234_5678, itoa_pkg::KIND_HEX_LO, 1'b0, 1'b0));
        send_word(make_item(64'sh00ab_cdef_1234_5678, itoa_pkg::KIND_HEX_UP, 1'b1, 1'b0));
        send_word(make_item(-64'sd12345, itoa_pkg::KIND_SDEC, 1'b1, 1'b0));
        // unused kind codes fall back to unsigned decimal
        send_word(make_item(-64'sd7, 3'd5, 1'b0, 1'b0));
        send_word(make_item(64'sd9876543210, 3'd6, 1'b1, 1'b1));
        send_word(make_item(-64'sd2, 3'd7, 1'b0, 1'b1));
        drain_text();
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < gap_pct)
                pause_cycles($urandom_range(1, 8));
            send_word(random_item());
        end
        drain_text();
    endtask

    initial
    begin
        board = new();
        cycles = 0;
        gap_pct = 0;
        rst_n <= 1'b0;
        start <= 1'b0;
        item <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_words();
        gap_pct = 11;
        random_phase(RANDOM_ITEMS / 3);
        gap_pct = 55;
        random_phase(RANDOM_ITEMS / 3);
        gap_pct = 0;
        random_phase(RANDOM_ITEMS / 3);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.pending() != 0)
        begin
            $display("%0d characters never arrived", board.pending());
            board.errors += board.pending();
        end

        $display("formatted %0d numbers over all kinds and sign flags, %0d characters compared",
                 board.numbers_seen, board.chars_checked);
        $display("extremes, unused kinds and sender gaps of 0, 11 and 55 percent exercised");
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
